// ===== design/prf_pkg.sv =====
`default_nettype none

package prf_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 16;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AGE_W      = 8;
    localparam int CNT_W      = 32;
    localparam int FRAMES_W   = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [AGE_W-1:0]    AGE_MAX       = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX       = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET  = 5'd16;

    typedef enum logic [0:0] {
        REG_POLICY = 1'b0,
        REG_FRAMES = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } t_policy;

    typedef struct packed {
        logic [15:0] page_number;
        logic        final_ref;
    } t_in_beat;

    typedef struct packed {
        logic        hit;
        logic        victim_valid;
        logic [15:0] victim_page;
        logic [31:0] fault_count;
        logic [31:0] hit_count;
        logic        run_done;
    } t_out_beat;

    typedef struct packed {
        t_policy             policy_mode;
        logic [FRAMES_W-1:0] frames_in_use;
    } t_cfg;

    // Search record that walks along the frame cells.
    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 final_ref;
        logic                 found;
        logic [IDX_W-1:0]     found_idx;
        logic [AGE_W-1:0]     found_age;
        logic                 empty_found;
        logic [IDX_W-1:0]     empty_idx;
        logic [IDX_W-1:0]     best_idx;
        logic [AGE_W-1:0]     best_age;
        logic [PAGE_BITS-1:0] best_page;
    } t_rec;

    // Update broadcast to every cell.
    typedef struct packed {
        logic                 clr;
        logic                 hit_lru;
        logic                 load;
        logic [IDX_W-1:0]     slot;
        logic [AGE_W-1:0]     ref_age;
        logic [PAGE_BITS-1:0] page;
    } t_upd;

    function automatic logic [PAGE_BITS-1:0] to_page(input logic [15:0] x);
        logic [47:0] w;
        w = {32'b0, x};
        return w[PAGE_BITS-1:0];
    endfunction

    function automatic logic [15:0] from_page(input logic [PAGE_BITS-1:0] p);
        logic [47:0] w;
        w = 48'(p);
        return w[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/prf_cell.sv =====
`default_nettype none

module prf_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [prf_pkg::IDX_W-1:0]  i_idx,
    input  wire logic                       i_active,
    input  wire prf_pkg::t_upd              i_upd,
    input  wire logic                       i_tok,
    input  wire prf_pkg::t_rec              i_rec,
    output logic                            o_tok,
    output prf_pkg::t_rec                   o_rec
);

    logic [prf_pkg::PAGE_BITS-1:0] r_page, n_page;
    logic                          r_valid, n_valid;
    logic [prf_pkg::AGE_W-1:0]     r_age, n_age;
    logic [prf_pkg::AGE_W-1:0]     age_inc;
    logic                          r_tok;
    prf_pkg::t_rec                 r_rec, n_rec;

    assign age_inc = (r_age == prf_pkg::AGE_MAX) ? r_age : r_age + 1'b1;

    // Search: first matching frame, first empty frame, oldest frame.
    always_comb begin
        n_rec = i_rec;
        if (i_active) begin
            if (!i_rec.found && r_valid && (r_page == i_rec.page)) begin
                n_rec.found     = 1'b1;
                n_rec.found_idx = i_idx;
                n_rec.found_age = r_age;
            end
            if (!i_rec.empty_found && !r_valid) begin
                n_rec.empty_found = 1'b1;
                n_rec.empty_idx   = i_idx;
            end
            // Strict compare keeps the lowest index on equal ages.
            if ((i_idx == '0) || (r_age > i_rec.best_age)) begin
                n_rec.best_idx  = i_idx;
                n_rec.best_age  = r_age;
                n_rec.best_page = r_page;
            end
        end
    end

    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        n_age   = r_age;
        if (i_upd.clr) begin
            n_valid = 1'b0;
            n_age   = '0;
        end else if (i_upd.load) begin
            if (i_idx == i_upd.slot) begin
                n_page  = i_upd.page;
                n_valid = 1'b1;
                n_age   = '0;
            end else if (i_active && r_valid) begin
                n_age = age_inc;
            end
        end else if (i_upd.hit_lru) begin
            if (i_idx == i_upd.slot) begin
                n_age = '0;
            end else if (i_active && r_valid && (r_age < i_upd.ref_age)) begin
                n_age = age_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
            r_tok   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_age   <= n_age;
            r_tok   <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_rec  <= n_rec;
    end

    assign o_tok = r_tok;
    assign o_rec = r_rec;

endmodule

`default_nettype wire

// ===== design/prf_apb_regs.sv =====
`default_nettype none

module prf_apb_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [prf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [prf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [prf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output prf_pkg::t_cfg                        o_cfg
);

    prf_pkg::t_cfg     r_cfg, n_cfg;
    prf_pkg::t_reg_idx reg_idx;
    logic              wr_en;

    assign reg_idx = prf_pkg::t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                prf_pkg::REG_POLICY: n_cfg.policy_mode   = prf_pkg::t_policy'(pwdata[0]);
                prf_pkg::REG_FRAMES: n_cfg.frames_in_use = pwdata[prf_pkg::FRAMES_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy_mode   <= prf_pkg::POLICY_FIFO;
            r_cfg.frames_in_use <= prf_pkg::FRAMES_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            prf_pkg::REG_POLICY: prdata = {31'b0, r_cfg.policy_mode};
            prf_pkg::REG_FRAMES: prdata = {27'b0, r_cfg.frames_in_use};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/page_replacement_fifo_lru_core.sv =====
// FIFO / LRU page replacement over a row of frame cells.
// Input channel (i_in_valid, o_in_ready, i_in_data) takes one page reference
// per beat; the output channel (o_out_valid, i_out_ready, o_out_data) returns
// one result beat per reference: hit or fault, the evicted page, and the
// saturating fault and hit counts of the current sequence.
// The APB port holds the policy mode (address 0) and the active frame count
// (address 4); write them only while the block is idle.
// A reference walks the cell chain one frame per cycle, gathering the first
// match, the first empty frame and the oldest frame, and the update is then
// broadcast to all cells at once. The reference passes through the input
// register, the cell registers and the tail register; one reference is in
// flight at a time, and a new one is taken only when the last has finished.
// When the receiver stalls, the previous result stays in the output
// register and the finished search waits in the tail register, its update
// held until the output register is free.
// Reset empties all frames, clears ages and counts, selects FIFO and sets
// the active count to 16. The reference after a final_ref beat starts a new
// sequence: frames are emptied and counts cleared before it is handled.
`default_nettype none

module page_replacement_fifo_lru_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire prf_pkg::t_in_beat               i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output prf_pkg::t_out_beat                   o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [prf_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [prf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [prf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int M = prf_pkg::MAX_FRAMES;

    prf_pkg::t_cfg      cfg;
    logic [M:0]         w_tok;
    prf_pkg::t_rec      w_rec [M+1];
    logic [M-1:0]       active;
    prf_pkg::t_upd      upd;

    logic               r_busy, n_busy;
    logic               r_seq_ended, n_seq_ended;
    logic [prf_pkg::CNT_W-1:0] r_fault_cnt, n_fault_cnt;
    logic [prf_pkg::CNT_W-1:0] r_hit_cnt, n_hit_cnt;
    logic               r_inj_tok;
    prf_pkg::t_rec      r_inj, n_inj;
    logic               r_tail_tok, n_tail_tok;
    prf_pkg::t_rec      r_tail;
    logic               r_out_valid, n_out_valid;
    prf_pkg::t_out_beat r_out, n_out;

    logic               accept;
    logic               finish;
    logic               seq_clear;

    prf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_in_ready = !r_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign finish     = r_tail_tok && (!r_out_valid || i_out_ready);
    assign seq_clear  = accept && r_seq_ended;

    assign w_tok[0] = r_inj_tok;
    assign w_rec[0] = r_inj;

    genvar g;
    generate
        for (g = 0; g < M; g++) begin : g_cell
            // A count of zero still uses frame 0; counts above the row use all.
            assign active[g] = (g == 0) ? 1'b1
                             : (32'(cfg.frames_in_use) > 32'(g));

            prf_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_idx    (prf_pkg::IDX_W'(g)),
                .i_active (active[g]),
                .i_upd    (upd),
                .i_tok    (w_tok[g]),
                .i_rec    (w_rec[g]),
                .o_tok    (w_tok[g+1]),
                .o_rec    (w_rec[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_inj             = '0;
        n_inj.page        = prf_pkg::to_page(i_in_data.page_number);
        n_inj.final_ref   = i_in_data.final_ref;
    end

    // Replacement decision from the finished search record.
    always_comb begin
        upd         = '0;
        upd.clr     = seq_clear;
        upd.page    = r_tail.page;
        upd.ref_age = r_tail.found_age;
        n_out       = r_out;
        n_fault_cnt = r_fault_cnt;
        n_hit_cnt   = r_hit_cnt;
        if (seq_clear) begin
            n_fault_cnt = '0;
            n_hit_cnt   = '0;
        end
        if (r_tail.found) begin
            upd.slot    = r_tail.found_idx;
            upd.hit_lru = finish && (cfg.policy_mode == prf_pkg::POLICY_LRU);
        end else begin
            upd.slot = r_tail.empty_found ? r_tail.empty_idx : r_tail.best_idx;
            upd.load = finish;
        end
        if (finish) begin
            if (r_tail.found) begin
                if (r_hit_cnt != prf_pkg::CNT_MAX) begin
                    n_hit_cnt = r_hit_cnt + 1'b1;
                end
            end else if (r_fault_cnt != prf_pkg::CNT_MAX) begin
                n_fault_cnt = r_fault_cnt + 1'b1;
            end
            n_out.hit          = r_tail.found;
            n_out.victim_valid = !r_tail.found && !r_tail.empty_found;
            n_out.victim_page  = (!r_tail.found && !r_tail.empty_found)
                               ? prf_pkg::from_page(r_tail.best_page) : 16'd0;
            n_out.fault_count  = n_fault_cnt;
            n_out.hit_count    = n_hit_cnt;
            n_out.run_done     = r_tail.final_ref;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_seq_ended = r_seq_ended;
        n_tail_tok  = r_tail_tok;
        n_out_valid = r_out_valid;
        if (accept) begin
            n_busy      = 1'b1;
            n_seq_ended = 1'b0;
        end
        if (w_tok[M]) begin
            n_tail_tok = 1'b1;
        end
        if (finish) begin
            n_busy      = 1'b0;
            n_tail_tok  = 1'b0;
            n_out_valid = 1'b1;
            n_seq_ended = r_tail.final_ref;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_seq_ended <= 1'b0;
            r_fault_cnt <= '0;
            r_hit_cnt   <= '0;
            r_inj_tok   <= 1'b0;
            r_tail_tok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_seq_ended <= n_seq_ended;
            r_fault_cnt <= n_fault_cnt;
            r_hit_cnt   <= n_hit_cnt;
            r_inj_tok   <= accept;
            r_tail_tok  <= n_tail_tok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_inj <= n_inj;
        end
        if (w_tok[M]) begin
            r_tail <= w_rec[M];
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_tail_tok, w_tok}) <= 1)
        else $error("more than one reference in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> ((w_tok == '0) && !r_tail_tok))
        else $error("search token present while idle");

    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished reference produced no result");

    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.hit && r_out.victim_valid))
        else $error("hit reported with an evicted page");

    a_clear_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_clear |=> ((r_fault_cnt == '0) && (r_hit_cnt == '0)))
        else $error("counts not cleared at sequence start");
`endif

endmodule

`default_nettype wire
